// ===== sv/oms_pkg.sv =====
`timescale 1ns / 1ps

package oms_pkg;

  localparam int unsigned SlotMax          = 6;
  localparam int unsigned SlotCountDefault = 6;

  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned DtWidth     = 8;
  localparam int unsigned IdxWidth    = 3;

  localparam logic [CfgWidth-1:0] SatMax = {CfgWidth{1'b1}};

  // register map of the configuration port
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgSlot0        = 3'd0,
    CfgSlot1        = 3'd1,
    CfgSlot2        = 3'd2,
    CfgSlot3        = 3'd3,
    CfgSlot4        = 3'd4,
    CfgSlot5        = 3'd5,
    CfgSilenceLimit = 3'd6
  } cfg_idx_e;

  localparam logic [CfgWidth-1:0] SilenceLimitReset = 16'd500;

  typedef struct packed {
    logic                valid;
    logic [IdxWidth-1:0] index;
  } slot_sel_t;

  function automatic logic [CfgWidth-1:0] interval_reset(input cfg_idx_e idx);
    logic [CfgWidth-1:0] v;
    case (idx)
      CfgSlot0: v = 16'd500;
      CfgSlot1: v = 16'd200;
      CfgSlot2: v = 16'd100;
      CfgSlot3: v = 16'd2000;
      CfgSlot4: v = 16'd3000;
      CfgSlot5: v = 16'd400;
      default:  v = '0;
    endcase
    return v;
  endfunction

  // 16-bit add of an 8-bit step, sticking at all ones
  function automatic logic [CfgWidth-1:0] add_sat16(input logic [CfgWidth-1:0] a,
                                                    input logic [DtWidth-1:0]  b);
    logic [CfgWidth:0] s;
    s = {1'b0, a} + {{(CfgWidth - DtWidth + 1){1'b0}}, b};
    return s[CfgWidth] ? SatMax : s[CfgWidth-1:0];
  endfunction

endpackage

// ===== sv/oms_if.sv =====
`timescale 1ns / 1ps

// tick channel
interface oms_in_if;
  import oms_pkg::*;

  logic               valid;
  logic               ready;
  logic [DtWidth-1:0] dt_ms;
  logic               sensor_seen;
  logic               boot_done;

  modport source (output valid, output dt_ms, output sensor_seen, output boot_done,
                  input ready);
  modport sink   (input valid, input dt_ms, input sensor_seen, input boot_done,
                  output ready);
endinterface

// result channel
interface oms_out_if;
  import oms_pkg::*;

  logic                valid;
  logic                ready;
  logic                slot_valid;
  logic [IdxWidth-1:0] slot_index;
  logic                sensor_fault;

  modport source (output valid, output slot_valid, output slot_index,
                  output sensor_fault, input ready);
  modport sink   (input valid, input slot_valid, input slot_index,
                  input sensor_fault, output ready);
endinterface

// ===== sv/oms_cfg_regs.sv =====
`timescale 1ns / 1ps

module oms_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [oms_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [oms_pkg::CfgWidth-1:0]  cfg_data_i,
  output logic [oms_pkg::CfgWidth-1:0]  interval_o [oms_pkg::SlotMax],
  output logic [oms_pkg::CfgWidth-1:0]  silence_limit_o
);
  import oms_pkg::*;

  logic [CfgWidth-1:0] interval_q [SlotMax];
  logic [CfgWidth-1:0] silence_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotMax; i++) begin
        interval_q[i] <= interval_reset(cfg_idx_e'(i));
      end
      silence_limit_q <= SilenceLimitReset;
    end else if (cfg_we_i) begin
      // indexes past the silence limit are dropped
      for (int i = 0; i < SlotMax; i++) begin
        if (cfg_idx_i == CfgIdxWidth'(i)) begin
          interval_q[i] <= cfg_data_i;
        end
      end
      if (cfg_idx_i == CfgSilenceLimit) begin
        silence_limit_q <= cfg_data_i;
      end
    end
  end

  assign interval_o      = interval_q;
  assign silence_limit_o = silence_limit_q;

endmodule

// ===== sv/oms_watchdog.sv =====
`timescale 1ns / 1ps

module oms_watchdog (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic [oms_pkg::DtWidth-1:0]  dt_i,
  input  logic                         seen_i,
  input  logic                         boot_i,
  input  logic [oms_pkg::CfgWidth-1:0] limit_i,
  output logic                         fault_o
);
  import oms_pkg::*;

  logic [CfgWidth-1:0] silence_q, silence_d;
  logic                fault_q, fault_d;
  logic [CfgWidth-1:0] silence_sum;

  always_comb begin
    silence_sum = add_sat16(silence_q, dt_i);
    silence_d   = silence_sum;
    fault_d     = fault_q;
    if (seen_i) begin
      silence_d = '0;
      fault_d   = 1'b0;
    end else if (boot_i && (silence_sum > limit_i)) begin
      silence_d = '0;
      fault_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silence_q <= '0;
      fault_q   <= 1'b0;
    end else if (advance_i) begin
      silence_q <= silence_d;
      fault_q   <= fault_d;
    end
  end

  // flag as it stands after this tick
  assign fault_o = fault_d;

endmodule

// ===== sv/oms_slot_sched.sv =====
`timescale 1ns / 1ps

module oms_slot_sched #(
  parameter int unsigned SlotCount = oms_pkg::SlotCountDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic [oms_pkg::DtWidth-1:0]  dt_i,
  input  logic [oms_pkg::CfgWidth-1:0] interval_i [oms_pkg::SlotMax],
  output oms_pkg::slot_sel_t           sel_o
);
  import oms_pkg::*;

  logic [CfgWidth-1:0]        elapsed_q [SlotCount];
  logic [CfgWidth-1:0]        elapsed_d [SlotCount];
  logic [CfgWidth-1:0]        advanced  [SlotCount];
  logic signed [CfgWidth:0]   due       [SlotCount];
  logic signed [CfgWidth:0]   best;
  slot_sel_t                  sel;

  always_comb begin
    // best starts at -1, so only slots with due >= 0 qualify
    best = '1;
    sel  = '0;
    for (int i = 0; i < SlotCount; i++) begin
      advanced[i] = add_sat16(elapsed_q[i], dt_i);
      due[i]      = signed'({1'b0, advanced[i]}) - signed'({1'b0, interval_i[i]});
      // strict compare keeps the lowest index on a tie
      if (due[i] > best) begin
        best      = due[i];
        sel.valid = 1'b1;
        sel.index = IdxWidth'(i);
      end
    end
    for (int i = 0; i < SlotCount; i++) begin
      elapsed_d[i] = (sel.valid && (sel.index == IdxWidth'(i))) ? '0 : advanced[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SlotCount; i++) begin
        elapsed_q[i] <= '0;
      end
    end else if (advance_i) begin
      elapsed_q <= elapsed_d;
    end
  end

  assign sel_o = sel;

endmodule

// ===== sv/overdue_message_scheduler_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake        Payload
// in_i      in   valid / ready    dt_ms[7:0], sensor_seen, boot_done
// out_o     out  valid / ready    slot_valid, slot_index[2:0], sensor_fault
// cfg       in   cfg_we_i only    cfg_idx_i[2:0], cfg_data_i[15:0]
//
// One tick per cycle sustained while the result side is ready. A tick is latched in
// the input register, is settled by the per-slot saturating add / subtract / compare
// lanes and lands in the result register when it advances.
// Reset restores the interval and limit defaults and clears all slot timers,
// the silence counter and the fault flag.
// A stalled result register holds the tick behind it in the input register;
// timers and watchdog only move when a tick passes into the result register.

module overdue_message_scheduler_unit #(
  parameter int unsigned SLOT_COUNT = oms_pkg::SlotCountDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  oms_in_if.sink                          in_i,
  oms_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [oms_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [oms_pkg::CfgWidth-1:0]    cfg_data_i
);
  import oms_pkg::*;

  // configuration
  logic [CfgWidth-1:0] interval [SlotMax];
  logic [CfgWidth-1:0] silence_limit;

  // input stage
  logic               s1_valid_q, s1_valid_d;
  logic [DtWidth-1:0] dt_q;
  logic               seen_q;
  logic               boot_q;

  // result stage
  logic                out_valid_q, out_valid_d;
  logic                slot_valid_q;
  logic [IdxWidth-1:0] slot_index_q;
  logic                fault_q;

  logic      in_accept;
  logic      advance;
  logic      fault;
  slot_sel_t sel;

  // a tick moves on when the result register is empty or being drained
  assign advance   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;

  oms_cfg_regs u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .interval_o      (interval),
    .silence_limit_o (silence_limit)
  );

  oms_watchdog u_wdog (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .dt_i      (dt_q),
    .seen_i    (seen_q),
    .boot_i    (boot_q),
    .limit_i   (silence_limit),
    .fault_o   (fault)
  );

  oms_slot_sched #(
    .SlotCount (SLOT_COUNT)
  ) u_sched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .dt_i       (dt_q),
    .interval_i (interval),
    .sel_o      (sel)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      dt_q   <= in_i.dt_ms;
      seen_q <= in_i.sensor_seen;
      boot_q <= in_i.boot_done;
    end
    if (advance) begin
      slot_valid_q <= sel.valid;
      slot_index_q <= sel.index;
      fault_q      <= fault;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.slot_valid   = slot_valid_q;
  assign out_o.slot_index   = slot_index_q;
  assign out_o.sensor_fault = fault_q;

endmodule

// ===== sv/oms_checker.sv =====
`timescale 1ns / 1ps

module oms_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         slot_valid_i,
  input logic [oms_pkg::IdxWidth-1:0] slot_index_i,
  input logic                         sensor_fault_i
);
  import oms_pkg::*;

  // an empty result register never blocks the tick side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input not ready while result register empty");

  // a fresh result must match an earlier accepted tick
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result appeared without a matching transaction");

  a_no_slot_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !slot_valid_i) |-> (slot_index_i == '0))
    else $error("slot index nonzero with no slot selected");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && slot_valid_i) |-> (slot_index_i < IdxWidth'(SlotMax)))
    else $error("slot index out of range");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable({slot_valid_i, slot_index_i, sensor_fault_i})))
    else $error("stalled result changed");

endmodule

bind overdue_message_scheduler_unit oms_checker u_oms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .slot_valid_i   (out_o.slot_valid),
  .slot_index_i   (out_o.slot_index),
  .sensor_fault_i (out_o.sensor_fault)
);
